### hw/rtl/obd_pkg.sv
// ----------------------------------------------------------------------------
// OBD reply parser package
// Shared types and constants for the reply value parser.
// ----------------------------------------------------------------------------
package obd_pkg;

  localparam int unsigned MaxReplyLen = 256;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CharTerm  = 8'd62;  // '>'
  localparam logic [7:0] CharFour  = 8'd52;  // '4'
  localparam logic [7:0] CharOne   = 8'd49;  // '1'
  localparam logic [7:0] CharRpm   = 8'd67;  // 'C'
  localparam logic [7:0] CharSpeed = 8'd68;  // 'D'

  localparam int unsigned KindPos = 3;

  // mph = floor(kmh * 62137 / 100000) via reciprocal, exact for 8-bit input
  localparam int unsigned SpeedNum   = 62137;
  localparam int unsigned SpeedDen   = 100000;
  localparam int unsigned SpeedShift = 26;
  localparam int unsigned RecipW     = 26;
  localparam longint unsigned SpeedRecip =
      ((longint'(SpeedNum) << SpeedShift) + longint'(SpeedDen) - 1) / longint'(SpeedDen);

  localparam int unsigned ValueW = 14;
  localparam int unsigned BcdW   = 16;
  localparam int unsigned DabW   = ValueW + BcdW;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindRpm   = 2'd1,
    KindSpeed = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] hex_val;
    logic        found;
  } item_t;

endpackage

### hw/rtl/obd_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that moves one reply character per word.
// ----------------------------------------------------------------------------
interface obd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

### hw/rtl/obd_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that moves one parsed reading per word.
// ----------------------------------------------------------------------------
interface obd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reading_kind;
  logic [13:0] reading_value;
  logic [15:0] decimal_digits;
  logic [2:0]  digit_count;
  logic        pair_found;

  modport source (output valid, output reading_kind, output reading_value,
                  output decimal_digits, output digit_count, output pair_found,
                  input ready);
  modport sink   (input valid, input reading_kind, input reading_value,
                  input decimal_digits, input digit_count, input pair_found,
                  output ready);
endinterface

### hw/rtl/obd_front.sv
// ----------------------------------------------------------------------------
// OBD front end
// Tracks character positions, finds the marker, captures the hex characters
// and emits a parsed item on the terminator.
// ----------------------------------------------------------------------------
module obd_front #(
  parameter int unsigned MAX_REPLY_LEN = obd_pkg::MaxReplyLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  obd_char_if.sink       char_i,
  output logic           push_valid_o,
  output obd_pkg::item_t push_item_o,
  input  logic           push_ready_i
);
  import obd_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_REPLY_LEN + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] mpos_q, mpos_d;
  logic [PosW-1:0] off;
  logic [7:0]      kind_char_q, kind_char_d;
  logic            last_four_q, last_four_d;
  logic            marker_q, marker_d;
  logic [7:0]      hex_q [4];
  logic [7:0]      hex_d [4];
  logic            accept;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'd48:8'd57]}) begin
      r = {1'b1, 4'(c - 8'd48)};
    end else if (c inside {[8'd65:8'd70]}) begin
      r = {1'b1, 4'(c - 8'd55)};
    end else if (c inside {[8'd97:8'd102]}) begin
      r = {1'b1, 4'(c - 8'd87)};
    end
    return r;
  endfunction

  function automatic logic [15:0] parse_hex(input logic [7:0] ch [4],
                                            input logic four_digits);
    logic [15:0] acc;
    logic        stop;
    logic [4:0]  d;
    acc  = '0;
    stop = 1'b0;
    for (int k = 0; k < 4; k++) begin
      d = hex_digit(ch[k]);
      if (!stop && d[4] && (k < 2 || four_digits)) begin
        acc = {acc[11:0], d[3:0]};
      end else begin
        stop = 1'b1;
      end
    end
    return acc;
  endfunction

  assign char_i.ready = push_ready_i;
  assign accept       = char_i.valid && push_ready_i;
  assign off          = pos_q - mpos_q;

  always_comb begin
    push_item_o.found = marker_q;
    if (kind_char_q == CharRpm) begin
      push_item_o.kind    = KindRpm;
      push_item_o.hex_val = parse_hex(hex_q, 1'b1);
    end else if (kind_char_q == CharSpeed) begin
      push_item_o.kind    = KindSpeed;
      push_item_o.hex_val = parse_hex(hex_q, 1'b0);
    end else begin
      push_item_o.kind    = KindNone;
      push_item_o.hex_val = '0;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    mpos_d       = mpos_q;
    kind_char_d  = kind_char_q;
    last_four_d  = last_four_q;
    marker_d     = marker_q;
    hex_d        = hex_q;
    push_valid_o = 1'b0;
    if (accept) begin
      if (char_i.rx_char == CharTerm) begin
        push_valid_o = 1'b1;
        pos_d        = '0;
        mpos_d       = '0;
        kind_char_d  = '0;
        last_four_d  = 1'b0;
        marker_d     = 1'b0;
        for (int i = 0; i < 4; i++) hex_d[i] = '0;
      end else if (pos_q < PosW'(MAX_REPLY_LEN)) begin
        if (pos_q == PosW'(KindPos)) kind_char_d = char_i.rx_char;
        if (marker_q) begin
          if (off == PosW'(6))       hex_d[0] = char_i.rx_char;
          else if (off == PosW'(7))  hex_d[1] = char_i.rx_char;
          else if (off == PosW'(9))  hex_d[2] = char_i.rx_char;
          else if (off == PosW'(10)) hex_d[3] = char_i.rx_char;
        end else if (last_four_q && char_i.rx_char == CharOne) begin
          marker_d    = 1'b1;
          mpos_d      = pos_q - PosW'(1);
          last_four_d = 1'b0;
        end else begin
          last_four_d = (char_i.rx_char == CharFour);
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mpos_q      <= '0;
      kind_char_q <= '0;
      last_four_q <= 1'b0;
      marker_q    <= 1'b0;
      for (int i = 0; i < 4; i++) hex_q[i] <= '0;
    end else begin
      pos_q       <= pos_d;
      mpos_q      <= mpos_d;
      kind_char_q <= kind_char_d;
      last_four_q <= last_four_d;
      marker_q    <= marker_d;
      hex_q       <= hex_d;
    end
  end

endmodule

### hw/rtl/obd_queue.sv
// ----------------------------------------------------------------------------
// OBD item queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module obd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  obd_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output obd_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);
  import obd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### hw/rtl/obd_back.sv
// ----------------------------------------------------------------------------
// OBD back end
// Scales the parsed value and converts it to BCD over three stages.
// ----------------------------------------------------------------------------
module obd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  obd_pkg::item_t pop_item_i,
  output logic           pop_ready_o,
  obd_result_if.source   result_o
);
  import obd_pkg::*;

  localparam int unsigned ProdW = 8 + RecipW;

  function automatic logic [DabW-1:0] dabble7(input logic [DabW-1:0] w);
    logic [DabW-1:0] t;
    t = w;
    for (int i = 0; i < 7; i++) begin
      for (int n = 0; n < 4; n++) begin
        if (t[ValueW + 4*n +: 4] >= 4'd5) t[ValueW + 4*n +: 4] = t[ValueW + 4*n +: 4] + 4'd3;
      end
      t = t << 1;
    end
    return t;
  endfunction

  logic              en;
  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] scaled;
  logic [ValueW-1:0] mod_val;
  logic [2:0]        count;

  // stage A: scaled value
  logic              va_q;
  kind_e             kind_a_q;
  logic              found_a_q;
  logic [ValueW-1:0] value_a_q;
  // stage B: half converted
  logic              vb_q;
  kind_e             kind_b_q;
  logic              found_b_q;
  logic [ValueW-1:0] value_b_q;
  logic [2:0]        count_b_q;
  logic [DabW-1:0]   dab_b_q;
  // output word
  logic              vo_q;
  kind_e             kind_o_q;
  logic              found_o_q;
  logic [ValueW-1:0] value_o_q;
  logic [2:0]        count_o_q;
  logic [DabW-1:0]   dab_o_q;

  assign en          = !vo_q || result_o.ready;
  assign pop_ready_o = en;

  assign prod = ProdW'(pop_item_i.hex_val[7:0]) * ProdW'(SpeedRecip);

  always_comb begin
    case (pop_item_i.kind)
      KindRpm:   scaled = ValueW'(pop_item_i.hex_val >> 2);
      KindSpeed: scaled = ValueW'(prod >> SpeedShift);
      default:   scaled = '0;
    endcase
  end

  assign mod_val = (value_a_q >= ValueW'(10000)) ? value_a_q - ValueW'(10000) : value_a_q;

  always_comb begin
    if (value_a_q >= ValueW'(1000))     count = 3'd4;
    else if (value_a_q >= ValueW'(100)) count = 3'd3;
    else if (value_a_q >= ValueW'(10))  count = 3'd2;
    else                                count = 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_a_q  <= pop_item_i.kind;
      found_a_q <= pop_item_i.found;
      value_a_q <= scaled;
      kind_b_q  <= kind_a_q;
      found_b_q <= found_a_q;
      value_b_q <= value_a_q;
      count_b_q <= count;
      dab_b_q   <= dabble7({BcdW'(0), mod_val});
      kind_o_q  <= kind_b_q;
      found_o_q <= found_b_q;
      value_o_q <= value_b_q;
      count_o_q <= count_b_q;
      dab_o_q   <= dabble7(dab_b_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= pop_valid_i;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  assign result_o.valid          = vo_q;
  assign result_o.reading_kind   = kind_o_q;
  assign result_o.reading_value  = value_o_q;
  assign result_o.decimal_digits = dab_o_q[DabW-1:ValueW];
  assign result_o.digit_count    = count_o_q;
  assign result_o.pair_found     = found_o_q;

endmodule

### hw/rtl/obd_response_value_parser_top.sv
// ----------------------------------------------------------------------------
// OBD reply value parser, top level
// Parses adapter reply characters into a scaled reading with BCD digits.
//
//   channel   dir  word
//   char_i    in   one reply character, '>' ends the reply
//   result_o  out  kind, value, BCD digits, digit count, marker flag
//
// One character accepted per cycle; ready drops only when the item queue
// is full. After its '>' is accepted, a result passes through the queue,
// then scale, first conversion half and second half into the output
// register. A stalled output holds the back end; the queue lets the front
// keep taking characters meanwhile. Reset clears all parse state.
// ----------------------------------------------------------------------------
module obd_response_value_parser_top #(
  parameter int unsigned MAX_REPLY_LEN = obd_pkg::MaxReplyLen
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  obd_char_if.sink     char_i,
  obd_result_if.source result_o
);
  import obd_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  obd_front #(
    .MAX_REPLY_LEN(MAX_REPLY_LEN)
  ) u_front (
    .clk_i,
    .rst_ni,
    .char_i,
    .push_valid_o(push_valid),
    .push_item_o (push_item),
    .push_ready_i(push_ready)
  );

  obd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i(push_valid),
    .push_item_i (push_item),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_ready_i (pop_ready)
  );

  obd_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i(pop_valid),
    .pop_item_i (pop_item),
    .pop_ready_o(pop_ready),
    .result_o
  );

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("item pushed into full queue");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.reading_kind == KindNone) |->
    (result_o.reading_value == '0 && result_o.decimal_digits == '0 &&
     result_o.digit_count == 3'd1))
    else $error("no-value result carries data");

  a_count_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.reading_value >= 14'd1000) |->
    result_o.digit_count == 3'd4)
    else $error("digit count mismatch");

endmodule

### test/tb_obd_response_value_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply value parser testbench
// Sends adapter replies one character per word and checks every parsed
// reading against a scoreboard fed by a built-in parser model or by a
// directed table of extremes and corner replies. After drain pauses come a
// long output hold-off, then random replies, idling randomly on both channels.
// ----------------------------------------------------------------------------
module tb_obd_response_value_parser_top;
  import obd_pkg::*;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned ItemTarget    = 100;
  localparam int unsigned ReadingTarget = 6;
  localparam logic [7:0]  CharCr        = 8'd13;
  localparam logic [7:0]  CharSpace     = 8'd32;
  localparam logic [7:0]  CharPad       = 8'd46;
  localparam logic [7:0]  CharZero      = 8'd48;

  typedef struct packed {
    kind_e       kind;
    logic [13:0] value;
    logic [15:0] digits;
    logic [2:0]  count;
    logic        found;
  } reading_t;

  typedef struct packed {
    logic     given;
    reading_t want;
  } spec_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  obd_char_if   char_if ();
  obd_result_if result_if ();

  obd_response_value_parser_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .char_i   (char_if),
    .result_o (result_if)
  );

  always #1 clk = ~clk;

  // parser model state
  int unsigned rx_pos;
  logic [7:0]  kind_sel;
  logic        prev_four;
  logic        have_marker;
  int unsigned marker_at;
  logic [7:0]  captured [4];

  reading_t    pending_readings [$];
  spec_t       reply_specs [$];
  int unsigned mismatches       = 0;
  int unsigned chars_taken      = 0;
  int unsigned readings_checked = 0;
  logic        calm             = 1'b0;
  logic        hold_req         = 1'b0;

  // directed table
  string       probe_text [$];
  int unsigned probe_pad [$];
  spec_t       probe_spec [$];

  function automatic void clear_parse();
    rx_pos      = 0;
    kind_sel    = 8'd0;
    prev_four   = 1'b0;
    have_marker = 1'b0;
    marker_at   = 0;
    for (int i = 0; i < 4; i++) captured[i] = 8'd0;
  endfunction

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] d);
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = 4'(c - 8'h37);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = 4'(c - 8'h57);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reading_t scale_reading();
    reading_t    r;
    logic [15:0] hex;
    logic [3:0]  nib;
    int unsigned used;
    int unsigned limit;
    int unsigned v;
    int unsigned m;
    hex   = 16'd0;
    used  = 0;
    limit = (kind_sel == CharSpeed) ? 2 : 4;
    while (used < limit && hex_digit(captured[used], nib)) begin
      hex = {hex[11:0], nib};
      used++;
    end
    r.kind = KindNone;
    v      = 0;
    if (kind_sel == CharRpm) begin
      r.kind = KindRpm;
      v      = hex / 4;
    end else if (kind_sel == CharSpeed) begin
      r.kind = KindSpeed;
      v      = (int'(hex) * SpeedNum) / SpeedDen;
    end
    v       = v & 32'h3FFF;
    r.value = 14'(v);
    r.count = (v >= 1000) ? 3'd4 : (v >= 100) ? 3'd3 : (v >= 10) ? 3'd2 : 3'd1;
    m       = v % 10000;
    r.digits = {4'(m / 1000), 4'((m / 100) % 10), 4'((m / 10) % 10), 4'(m % 10)};
    r.found  = have_marker;
    return r;
  endfunction

  // returns 1 when the word closes a reply
  function automatic logic absorb_char(input logic [7:0] c, output reading_t r);
    int unsigned off;
    r = '0;
    if (c == CharTerm) begin
      r = scale_reading();
      clear_parse();
      return 1'b1;
    end
    if (rx_pos >= MaxReplyLen) return 1'b0;
    if (rx_pos == KindPos) kind_sel = c;
    if (have_marker) begin
      off = rx_pos - marker_at;
      case (off)
        6:  captured[0] = c;
        7:  captured[1] = c;
        9:  captured[2] = c;
        10: captured[3] = c;
        default: ;
      endcase
    end else if (prev_four && c == CharOne) begin
      have_marker = 1'b1;
      marker_at   = rx_pos - 1;
      prev_four   = 1'b0;
    end else begin
      prev_four = (c == CharFour);
    end
    rx_pos++;
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    reading_t ahead;
    spec_t    spec;
    if (rst_n) begin
      if (result_if.valid && result_if.ready) begin
        readings_checked++;
        if (pending_readings.size() == 0) begin
          mismatches++;
          $error("reading with none pending: kind %0d value %0d",
                 result_if.reading_kind, result_if.reading_value);
        end else begin
          want = pending_readings.pop_front();
          compare_field("reading_kind", want.kind, result_if.reading_kind);
          compare_field("reading_value", want.value, result_if.reading_value);
          compare_field("decimal_digits", want.digits, result_if.decimal_digits);
          compare_field("digit_count", want.count, result_if.digit_count);
          compare_field("pair_found", want.found, result_if.pair_found);
        end
      end
      if (char_if.valid && char_if.ready) begin
        if (char_if.rx_char == CharTerm || rx_pos < MaxReplyLen) chars_taken++;
        if (absorb_char(char_if.rx_char, ahead)) begin
          spec = reply_specs.pop_front();
          pending_readings.push_back(spec.given ? spec.want : ahead);
        end
      end
    end
  end

  initial begin
    result_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      result_if.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == CharTerm) ? CharPad : c;
  endfunction

  function automatic void add_probe(input string text, input int unsigned pad,
                                    input logic given, input kind_e kind,
                                    input int unsigned value, input logic [15:0] digits,
                                    input int unsigned count, input logic found);
    spec_t s;
    s.given       = given;
    s.want.kind   = kind;
    s.want.value  = 14'(value);
    s.want.digits = digits;
    s.want.count  = 3'(count);
    s.want.found  = found;
    probe_text.push_back(text);
    probe_pad.push_back(pad);
    probe_spec.push_back(s);
  endfunction

  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(99) < 15) begin
      char_if.valid <= 1'b0;
      @(negedge clk);
    end
    char_if.valid   <= 1'b1;
    char_if.rx_char <= c;
    do @(posedge clk); while (!char_if.ready);
    @(negedge clk);
  endtask

  task automatic send_reply(input logic [7:0] body [$], input spec_t spec);
    reply_specs.push_back(spec);
    foreach (body[i]) send_char(body[i]);
    send_char(CharTerm);
  endtask

  task automatic wait_drain();
    char_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic compose_reply(output logic [7:0] body [$]);
    string       hex_set = "0123456789abcdefABCDEF";
    logic [7:0]  kind;
    logic [7:0]  c;
    int unsigned pick;
    int unsigned nbytes;
    int unsigned cut;
    body = {};
    pick = $urandom_range(99);
    if (pick < 20) begin
      repeat ($urandom_range(12)) body.push_back(noise_char());
      if ($urandom_range(29) == 0) repeat ($urandom_range(300, 260)) body.push_back(noise_char());
      return;
    end
    kind = $urandom_range(1) ? CharRpm : CharSpeed;
    if ($urandom_range(9) == 0) kind = noise_char();
    body = {CharZero, CharOne, CharZero, kind, CharCr};
    if ($urandom_range(9) != 0) begin
      body = {body, CharFour, CharOne, CharSpace, CharZero, kind, CharSpace};
      nbytes = (kind == CharRpm) ? 2 : 1;
      if ($urandom_range(4) == 0) nbytes = $urandom_range(3, 1);
      repeat (nbytes) begin
        repeat (2) begin
          c = hex_set[$urandom_range(21)];
          if ($urandom_range(11) == 0) c = noise_char();
          body.push_back(c);
        end
        body.push_back(CharSpace);
      end
    end
    if ($urandom_range(1)) body = {body, CharCr, CharCr};
    if (pick >= 85) begin
      cut = $urandom_range(body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
  endtask

  initial begin
    logic [7:0]  body [$];
    int unsigned n;
    char_if.valid   = 1'b0;
    char_if.rx_char = 8'd0;
    clear_parse();

    add_probe("", 0, 1'b1, KindNone, 0, 16'h0000, 1, 1'b0);
    add_probe("01", 0, 1'b1, KindNone, 0, 16'h0000, 1, 1'b0);
    add_probe("010C", 0, 1'b1, KindRpm, 0, 16'h0000, 1, 1'b0);
    add_probe("010C\01541 0C FF FF ", 0, 1'b1, KindRpm, 16383, 16'h6383, 4, 1'b1);
    add_probe("010D\01541 0D FF ", 0, 1'b1, KindSpeed, 158, 16'h0158, 3, 1'b1);
    add_probe("010D\01541 0D 00", 0, 1'b1, KindSpeed, 0, 16'h0000, 1, 1'b1);
    add_probe("010C\01541 0C 00 03", 0, 1'b1, KindRpm, 0, 16'h0000, 1, 1'b1);
    add_probe("010C\01541 0C 0f a0 ", 0, 1'b1, KindRpm, 1000, 16'h1000, 4, 1'b1);
    add_probe("0100\01541 00 BE 3F", 0, 1'b1, KindNone, 0, 16'h0000, 1, 1'b1);
    add_probe("410C\01541 0C 2a bz", 0, 1'b0, KindNone, 0, 16'h0000, 0, 1'b0);
    add_probe("010C\01541 0C 1G 23", 0, 1'b0, KindNone, 0, 16'h0000, 0, 1'b0);
    add_probe("010C\01541 0C 12 3", 0, 1'b0, KindNone, 0, 16'h0000, 0, 1'b0);
    add_probe("010C\015441 0C 00 40", 0, 1'b0, KindNone, 0, 16'h0000, 0, 1'b0);
    add_probe("010D\01541 0D 7F", 250, 1'b0, KindNone, 0, 16'h0000, 0, 1'b0);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < probe_text.size(); p++) begin
      body = {};
      for (int i = 0; i < probe_text[p].len(); i++) body.push_back(probe_text[p][i]);
      repeat (probe_pad[p]) body.push_back(CharPad);
      send_reply(body, probe_spec[p]);
    end
    wait_drain();

    // output held off while short replies keep coming
    hold_req = 1'b1;
    repeat (12) begin
      body = {};
      repeat ($urandom_range(3)) body.push_back(noise_char());
      send_reply(body, '0);
    end
    wait_drain();

    chars_taken      = 0;
    readings_checked = 0;
    n = 0;
    while (chars_taken < ItemTarget || readings_checked < ReadingTarget) begin
      calm = (n >= 1 && n < 4);
      compose_reply(body);
      send_reply(body, '0);
      n++;
    end
    calm = 1'b0;

    wait_drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
